// ===== rtl/core/ide_pkg.sv =====
`default_nettype none

package ide_pkg;

  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChLess    = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam logic [2:0] KwLast = 3'd6;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_BYTE  = 2'd1,
    EV_DONE  = 2'd2
  } event_kind_e;

  typedef enum logic [3:0] {
    PH_KEYWORD = 4'b0001,
    PH_OPENER  = 4'b0010,
    PH_PATH    = 4'b0100,
    PH_IDLE    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic        valid;
    event_kind_e kind;
    logic [7:0]  data;
  } scan_event_t;

  function automatic logic [7:0] kw_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h69;
      3'd1: ch = 8'h6E;
      3'd2: ch = 8'h63;
      3'd3: ch = 8'h6C;
      3'd4: ch = 8'h75;
      3'd5: ch = 8'h64;
      3'd6: ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ide_scan.sv =====
`default_nettype none

module ide_scan import ide_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output scan_event_t      event_o
);

  logic       line_q, line_d;
  logic       block_q, block_d;
  logic [7:0] prev_q;
  phase_e     phase_q, phase_d;
  logic [2:0] kw_pos_q, kw_pos_d;
  logic       skip;

  always_comb begin
    line_d = line_q;
    if (byte_i == ChSlash && prev_q == ChSlash && !block_q) begin
      line_d = 1'b1;
    end
    if ((byte_i == ChLf || byte_i == ChCr) && line_d) begin
      line_d = 1'b0;
    end
    block_d = block_q;
    if (byte_i == ChStar && prev_q == ChSlash && !line_d) begin
      block_d = 1'b1;
    end
    if (byte_i == ChSlash && prev_q == ChStar) begin
      block_d = 1'b0;
    end
  end

  assign skip = line_d || block_d;

  always_comb begin
    phase_d       = phase_q;
    kw_pos_d      = kw_pos_q;
    event_o.valid = 1'b0;
    event_o.kind  = EV_START;
    event_o.data  = 8'h00;
    if (!skip) begin
      if (byte_i == ChHash) begin
        phase_d  = PH_KEYWORD;
        kw_pos_d = 3'd0;
      end else begin
        case (phase_q)
          PH_KEYWORD: begin
            if (kw_pos_q > KwLast || byte_i != kw_char(kw_pos_q)) begin
              phase_d = PH_IDLE;
            end else if (kw_pos_q == KwLast) begin
              phase_d = PH_OPENER;
            end else begin
              kw_pos_d = kw_pos_q + 3'd1;
            end
          end
          PH_OPENER: begin
            if (byte_i == ChSpace) begin
              phase_d = PH_OPENER;
            end else if (byte_i == ChDquote || byte_i == ChLess) begin
              phase_d       = PH_PATH;
              event_o.valid = 1'b1;
              event_o.kind  = EV_START;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_PATH: begin
            event_o.valid = 1'b1;
            if (byte_i == ChDquote || byte_i == ChGreater) begin
              phase_d      = PH_IDLE;
              event_o.kind = EV_DONE;
            end else begin
              event_o.kind = EV_BYTE;
              event_o.data = byte_i;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= 1'b0;
      block_q  <= 1'b0;
      prev_q   <= 8'h00;
      phase_q  <= PH_KEYWORD;
      kw_pos_q <= 3'd0;
    end else if (step_i) begin
      line_q   <= line_d;
      block_q  <= block_d;
      prev_q   <= byte_i;
      phase_q  <= phase_d;
      kw_pos_q <= kw_pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ide_out_reg.sv =====
`default_nettype none

module ide_out_reg import ide_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire scan_event_t event_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_kind_o,
  output logic [7:0]       path_byte_o
);

  logic        valid_q, valid_d;
  event_kind_e kind_q;
  logic [7:0]  data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = event_i.valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && event_i.valid) begin
      kind_q <= event_i.kind;
      data_q <= event_i.data;
    end
  end

  assign out_valid_o  = valid_q;
  assign event_kind_o = kind_q;
  assign path_byte_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/include_directive_extractor_unit.sv =====
// Channel | Handshake               | Payload
// in      | in_valid_i, in_ready_o  | text_byte_i[7:0]
// out     | out_valid_o, out_ready_i| event_kind_o[1:0], path_byte_o[7:0]
//
// One byte is taken per cycle unless a stalled result holds the input.
// The byte passes an input register, the scanner state machine and a result register.
// Reset clears the comment flags, previous byte and valid bits, and puts the matcher in its keyword phase.
// A stalled result holds the pipeline; a byte with no result frees its slot at once.
`default_nettype none

module include_directive_extractor_unit import ide_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      event_kind_o,
  output logic [7:0]      path_byte_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        free;
  logic        step;
  scan_event_t scan_event;

  assign step       = in_valid_q && free;
  assign in_ready_o = !in_valid_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= text_byte_i;
    end
  end

  ide_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .event_o (scan_event)
  );

  ide_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .event_i      (scan_event),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .path_byte_o  (path_byte_o)
  );

endmodule

`default_nettype wire

// ===== tb/include_path_checker.sv =====
`default_nettype none

module include_path_checker import ide_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [1:0] event_kind_i,
  input  wire logic [7:0] path_byte_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SCAN_KEYWORD,
    SCAN_OPENER,
    SCAN_PATH,
    SCAN_IDLE
  } scan_phase_e;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  data;
  } path_event_t;

  localparam logic [55:0] KeywordText = "include";

  logic        line_cmt;
  logic        block_cmt;
  logic [7:0]  last_byte;
  scan_phase_e phase;
  logic [2:0]  kw_pos;
  path_event_t expected_q[$];
  int          fails = 0;

  assign fail_count_o = fails;

  function automatic bit scan_text_byte(input logic [7:0] b, output path_event_t ev);
    logic [7:0] p;
    p  = last_byte;
    ev = '{EV_START, 8'h00};
    if (b == ChSlash && p == ChSlash && !block_cmt) line_cmt = 1'b1;
    if ((b == ChLf || b == ChCr) && line_cmt) line_cmt = 1'b0;
    if (b == ChStar && p == ChSlash && !line_cmt) block_cmt = 1'b1;
    if (b == ChSlash && p == ChStar) block_cmt = 1'b0;
    last_byte = b;
    if (line_cmt || block_cmt) return 1'b0;
    if (b == ChHash) begin
      phase  = SCAN_KEYWORD;
      kw_pos = 3'd0;
      return 1'b0;
    end
    case (phase)
      SCAN_KEYWORD: begin
        if (kw_pos > KwLast ||
            b != KeywordText[8 * (int'(KwLast) - int'(kw_pos)) +: 8]) begin
          phase = SCAN_IDLE;
        end else if (kw_pos == KwLast) begin
          phase = SCAN_OPENER;
        end else begin
          kw_pos = kw_pos + 3'd1;
        end
        return 1'b0;
      end
      SCAN_OPENER: begin
        if (b == ChSpace) return 1'b0;
        if (b == ChDquote || b == ChLess) begin
          phase = SCAN_PATH;
          return 1'b1;
        end
        phase = SCAN_IDLE;
        return 1'b0;
      end
      SCAN_PATH: begin
        if (b == ChDquote || b == ChGreater) begin
          phase   = SCAN_IDLE;
          ev.kind = EV_DONE;
          return 1'b1;
        end
        ev.kind = EV_BYTE;
        ev.data = b;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    path_event_t ev;
    path_event_t want;
    if (!rst_ni) begin
      line_cmt  = 1'b0;
      block_cmt = 1'b0;
      last_byte = 8'h00;
      phase     = SCAN_KEYWORD;
      kw_pos    = 3'd0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, kind %0d byte %02h",
                                    event_kind_i, path_byte_i));
        end else begin
          want = expected_q.pop_front();
          if (event_kind_i !== want.kind)
            report_mismatch($sformatf("event kind %0d, expected %0d",
                                      event_kind_i, want.kind));
          if (path_byte_i !== want.data)
            report_mismatch($sformatf("path byte %02h, expected %02h",
                                      path_byte_i, want.data));
        end
      end
      if (in_valid_i && in_ready_i && scan_text_byte(text_byte_i, ev))
        expected_q.push_back(ev);
    end
    pending_o = expected_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ide_pkg::*;

  localparam int RandomBytes = 800;
  localparam int QuietFrom   = 680;
  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 80;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] event_kind;
  logic [7:0] path_byte;
  int         fail_count;
  int         pending;
  bit         quiet = 1'b0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;
  int         sent = 0;
  int         idle_cycles = 0;

  include_directive_extractor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .text_byte_i (text_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .event_kind_o(event_kind),
    .path_byte_o (path_byte)
  );

  include_path_checker u_path_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .text_byte_i (text_byte),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .event_kind_i(event_kind),
    .path_byte_i (path_byte),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && !calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] path_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h21, 8'h7E));
    end while (c == ChDquote || c == ChGreater || c == ChHash);
    return c;
  endfunction

  task automatic send_directive(input int path_len, input bit broken);
    string kw;
    int    flaw;
    kw   = "include";
    flaw = broken ? $urandom_range(0, 4) : 5;
    if (flaw == 0) kw[$urandom_range(0, 6)] = 8'($urandom_range(8'h61, 8'h7A));
    if (flaw == 1) kw = kw.substr(0, $urandom_range(0, 5));
    send_byte(ChHash);
    send_text(kw);
    repeat ($urandom_range(0, 2)) send_byte(ChSpace);
    if (flaw == 2) send_byte(8'($urandom_range(8'h21, 8'h7E)));
    send_byte($urandom_range(0, 1) ? ChDquote : ChLess);
    for (int i = 0; i < path_len; i++) begin
      if (flaw == 3 && i == path_len / 2) send_byte(ChHash);
      send_byte(path_char());
    end
    if (flaw != 4) send_byte($urandom_range(0, 1) ? ChDquote : ChGreater);
  endtask

  task automatic send_line_comment();
    logic [7:0] c;
    send_text("//");
    if ($urandom_range(0, 1)) send_text("#include<p>");
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom); while (c == ChLf || c == ChCr);
      send_byte(c);
    end
    send_byte($urandom_range(0, 1) ? ChLf : ChCr);
  endtask

  task automatic send_block_comment();
    logic [7:0] c;
    send_text("/*");
    if ($urandom_range(0, 1)) send_text("#include\"q\"");
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom); while (c == ChStar);
      send_byte(c);
    end
    send_text("*/");
  endtask

  task automatic send_noise();
    string specials;
    specials = "#/*\n\r\"<> ie";
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1)) send_byte(8'($urandom));
      else send_byte(specials[$urandom_range(0, specials.len() - 1)]);
    end
  endtask

  initial begin
    int hold_at;
    int rnd_start;
    bit held;
    held = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The scanner starts out matching the keyword, so no leading hash is needed here.
    send_text("include \"");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChGreater);
    send_text("#include<x#include<\"");

    // Let every pending transfer drain before the random part.
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);

    hold_at   = $urandom_range(150, 400);
    rnd_start = sent;
    while (sent - rnd_start < RandomBytes) begin
      calm  = ($urandom_range(0, 3) == 0);
      quiet = (sent - rnd_start > QuietFrom);
      if (!held && sent - rnd_start >= hold_at) begin
        held     = 1'b1;
        hold_req = 1'b1;
        send_directive(24, 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_directive($urandom_range(0, 6), $urandom_range(0, 3) == 0);
          6: send_line_comment();
          7: send_block_comment();
          default: send_noise();
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== include_directive_extractor_unit.f =====
rtl/core/ide_pkg.sv
rtl/core/ide_scan.sv
rtl/core/ide_out_reg.sv
rtl/core/include_directive_extractor_unit.sv
tb/include_path_checker.sv
tb/testbench.sv
